/* hdl/svge_pkg.sv */
// Package for the state vector gate engine: widths, command codes, config indexes.
// No dependencies.
`timescale 1ns / 1ps
package svge_pkg;
  localparam int QUBITS    = 10;
  localparam int FRAC_BITS = 16;
  localparam int AW        = QUBITS;
  localparam int DEPTH     = 1 << QUBITS;
  localparam int DW        = 18;
  localparam int QW        = 4;
  localparam int ONE       = 1 << FRAC_BITS;

  typedef enum logic [2:0] {
    CMD_WRITE   = 3'd0,
    CMD_READ    = 3'd1,
    CMD_RESET   = 3'd2,
    CMD_GATE    = 3'd3,
    CMD_CNOT    = 3'd4,
    CMD_TOFFOLI = 3'd5
  } cmd_t;

  localparam logic [2:0] CFG_R00 = 3'd0;
  localparam logic [2:0] CFG_I00 = 3'd1;
  localparam logic [2:0] CFG_R01 = 3'd2;
  localparam logic [2:0] CFG_I01 = 3'd3;
  localparam logic [2:0] CFG_R10 = 3'd4;
  localparam logic [2:0] CFG_I10 = 3'd5;
  localparam logic [2:0] CFG_R11 = 3'd6;
  localparam logic [2:0] CFG_I11 = 3'd7;

  // Operation after classification by the front end.
  typedef enum logic [2:0] {
    OP_NONE, OP_WRITE, OP_READ, OP_RESET, OP_GATE, OP_SWAP
  } op_t;

  typedef struct packed {
    op_t                   op;
    logic [AW-1:0]         idx;
    logic signed [DW-1:0]  wr_re;
    logic signed [DW-1:0]  wr_im;
    logic [AW-1:0]         tmask;
    logic [AW-1:0]         cmask;
  } job_t;

  // Clamp to -1.0 .. +1.0.
  function automatic logic signed [DW-1:0] sat18(input logic signed [47:0] v);
    logic signed [47:0] one;
    one = 48'(ONE);
    if (v > one) return DW'(ONE);
    if (v < -one) return DW'(-ONE);
    return v[DW-1:0];
  endfunction
endpackage

/* hdl/svge_front.sv */
// Front end: takes commands, checks qubit numbers and builds a job for the back end.
// Depends on svge_pkg.
`timescale 1ns / 1ps
module svge_front (
  input  logic                          in_start,
  output logic                          in_busy,
  input  logic [2:0]                    in_cmd,
  input  logic [svge_pkg::AW-1:0]       in_amp_index,
  input  logic signed [svge_pkg::DW-1:0] in_real,
  input  logic signed [svge_pkg::DW-1:0] in_imag,
  input  logic [svge_pkg::QW-1:0]       in_target_qubit,
  input  logic [svge_pkg::QW-1:0]       in_control_qubit_a,
  input  logic [svge_pkg::QW-1:0]       in_control_qubit_b,
  input  logic                          q_full,
  output logic                          q_push,
  output svge_pkg::job_t                q_job
);
  logic              t_ok, a_ok, b_ok;
  logic [svge_pkg::AW-1:0] tm, am, bm;

  assign in_busy = q_full;
  assign q_push  = in_start && !q_full;

  assign t_ok = in_target_qubit < svge_pkg::QW'(svge_pkg::QUBITS);
  assign a_ok = in_control_qubit_a < svge_pkg::QW'(svge_pkg::QUBITS);
  assign b_ok = in_control_qubit_b < svge_pkg::QW'(svge_pkg::QUBITS);
  assign tm = svge_pkg::AW'(1) << in_target_qubit;
  assign am = svge_pkg::AW'(1) << in_control_qubit_a;
  assign bm = svge_pkg::AW'(1) << in_control_qubit_b;

  always_comb begin
    q_job       = '0;
    q_job.idx   = in_amp_index;
    q_job.wr_re = svge_pkg::sat18(48'(in_real));
    q_job.wr_im = svge_pkg::sat18(48'(in_imag));
    q_job.tmask = tm;
    q_job.op    = svge_pkg::OP_NONE;
    case (in_cmd)
      svge_pkg::CMD_WRITE: q_job.op = svge_pkg::OP_WRITE;
      svge_pkg::CMD_READ:  q_job.op = svge_pkg::OP_READ;
      svge_pkg::CMD_RESET: q_job.op = svge_pkg::OP_RESET;
      svge_pkg::CMD_GATE:  if (t_ok) q_job.op = svge_pkg::OP_GATE;
      svge_pkg::CMD_CNOT: begin
        q_job.cmask = am;
        // control equal to target never matches, so no pair moves
        if (t_ok && a_ok && in_control_qubit_a != in_target_qubit)
          q_job.op = svge_pkg::OP_SWAP;
      end
      svge_pkg::CMD_TOFFOLI: begin
        q_job.cmask = am | bm;
        if (t_ok && a_ok && b_ok && in_control_qubit_a != in_target_qubit &&
            in_control_qubit_b != in_target_qubit)
          q_job.op = svge_pkg::OP_SWAP;
      end
      default: q_job.op = svge_pkg::OP_NONE;
    endcase
  end
endmodule

/* hdl/svge_queue.sv */
// Two-entry job queue between front and back end.
// Depends on svge_pkg.
`timescale 1ns / 1ps
module svge_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  svge_pkg::job_t push_job,
  output logic           full,
  input  logic           pop,
  output logic           not_empty,
  output svge_pkg::job_t head
);
  svge_pkg::job_t mem_r [2];
  logic           wp_r, rp_r;
  logic [1:0]     cnt_r;

  assign full      = cnt_r == 2'd2;
  assign not_empty = cnt_r != 2'd0;
  assign head      = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_job;
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= !wp_r;
      if (pop) rp_r <= !rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end
endmodule

/* hdl/svge_back.sv */
// Back end: amplitude memories, clearing sweep, gate datapath and swaps.
// Depends on svge_pkg.
`timescale 1ns / 1ps
module svge_back (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           q_valid,
  input  svge_pkg::job_t                 q_job,
  output logic                           q_pop,
  input  logic signed [svge_pkg::DW-1:0] coef [8],
  output logic                           out_strobe,
  output logic signed [svge_pkg::DW-1:0] out_real,
  output logic signed [svge_pkg::DW-1:0] out_imag,
  output logic                           out_is_read_data
);
  localparam int AW = svge_pkg::AW;
  localparam int DW = svge_pkg::DW;
  localparam int PW = AW - 1;

  typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_READ, S_GATE, S_SWAP} state_t;

  logic signed [DW-1:0] mem_re [svge_pkg::DEPTH];
  logic signed [DW-1:0] mem_im [svge_pkg::DEPTH];

  state_t               state_r;
  svge_pkg::job_t       job_r;
  logic [AW:0]          cnt_r;     // pair counter (amplitude counter while clearing), extra bit marks end of sweep
  logic                 out_strobe_r, out_isrd_r;
  logic signed [DW-1:0] out_re_r, out_im_r;

  // read port addresses and write ports
  logic [AW-1:0]        ra0, ra1, wa0, wa1;
  logic                 we0, we1;
  logic signed [DW-1:0] wd0_re, wd0_im, wd1_re, wd1_im;
  logic signed [DW-1:0] rd0_re_r, rd0_im_r, rd1_re_r, rd1_im_r;

  // pipeline: issue (p0) -> mem read (p1) -> products (p2) -> sum/round (write)
  logic                 v1_r, v2_r;
  logic [AW-1:0]        a1_i0_r, a1_i1_r, a2_i0_r, a2_i1_r;
  logic signed [35:0]   pr_r [16];

  function automatic logic [AW-1:0] pair_lo(input logic [PW-1:0] i,
                                            input logic [AW-1:0] tm);
    logic [AW-1:0] low, ie;
    low = tm - AW'(1);
    ie  = AW'(i);
    return ((ie & ~low) << 1) | (ie & low);
  endfunction

  logic [AW-1:0] i0, i1;
  logic          last_issue;
  assign i0 = pair_lo(cnt_r[PW-1:0], job_r.tmask);
  assign i1 = i0 | job_r.tmask;
  assign last_issue = cnt_r == (AW+1)'(svge_pkg::DEPTH/2 - 1);

  assign q_pop = (state_r == S_IDLE) && q_valid;

  // read path, registered
  always_comb begin
    ra0 = i0; ra1 = i1;
    if (state_r == S_IDLE) ra0 = q_job.idx;
  end
  always_ff @(posedge clk) begin
    rd0_re_r <= mem_re[ra0]; rd0_im_r <= mem_im[ra0];
    rd1_re_r <= mem_re[ra1]; rd1_im_r <= mem_im[ra1];
  end

  // products: a = entry i0, b = entry i1
  always_ff @(posedge clk) begin
    pr_r[0]  <= coef[0] * rd0_re_r; pr_r[1]  <= coef[1] * rd0_im_r;
    pr_r[2]  <= coef[2] * rd1_re_r; pr_r[3]  <= coef[3] * rd1_im_r;
    pr_r[4]  <= coef[0] * rd0_im_r; pr_r[5]  <= coef[1] * rd0_re_r;
    pr_r[6]  <= coef[2] * rd1_im_r; pr_r[7]  <= coef[3] * rd1_re_r;
    pr_r[8]  <= coef[4] * rd0_re_r; pr_r[9]  <= coef[5] * rd0_im_r;
    pr_r[10] <= coef[6] * rd1_re_r; pr_r[11] <= coef[7] * rd1_im_r;
    pr_r[12] <= coef[4] * rd0_im_r; pr_r[13] <= coef[5] * rd0_re_r;
    pr_r[14] <= coef[6] * rd1_im_r; pr_r[15] <= coef[7] * rd1_re_r;
  end

  function automatic logic signed [DW-1:0] rnd(input logic signed [39:0] acc);
    logic signed [39:0] s;
    s = (acc + 40'(1 << (svge_pkg::FRAC_BITS - 1))) >>> svge_pkg::FRAC_BITS;
    return svge_pkg::sat18(48'(s));
  endfunction

  logic signed [39:0] r0, m0, r1, m1;
  assign r0 = 40'(pr_r[0]) - 40'(pr_r[1]) + 40'(pr_r[2]) - 40'(pr_r[3]);
  assign m0 = 40'(pr_r[4]) + 40'(pr_r[5]) + 40'(pr_r[6]) + 40'(pr_r[7]);
  assign r1 = 40'(pr_r[8]) - 40'(pr_r[9]) + 40'(pr_r[10]) - 40'(pr_r[11]);
  assign m1 = 40'(pr_r[12]) + 40'(pr_r[13]) + 40'(pr_r[14]) + 40'(pr_r[15]);

  logic swap_hit;
  assign swap_hit = (a1_i0_r & job_r.cmask) == job_r.cmask;

  always_comb begin
    we0 = 1'b0; we1 = 1'b0;
    wa0 = a2_i0_r; wa1 = a2_i1_r;
    wd0_re = rnd(r0); wd0_im = rnd(m0);
    wd1_re = rnd(r1); wd1_im = rnd(m1);
    case (state_r)
      S_CLEAR: begin
        we0 = 1'b1; wa0 = cnt_r[AW-1:0];
        wd0_re = (cnt_r[AW-1:0] == '0) ? DW'(svge_pkg::ONE) : '0;
        wd0_im = '0;
      end
      S_IDLE: begin
        if (q_valid && q_job.op == svge_pkg::OP_WRITE) begin
          we0 = 1'b1; wa0 = q_job.idx; wd0_re = q_job.wr_re; wd0_im = q_job.wr_im;
        end
      end
      S_GATE: begin
        we0 = v2_r; we1 = v2_r;
      end
      S_SWAP: begin
        // swap the pair read last cycle when the controls match
        we0 = v1_r && swap_hit; we1 = we0;
        wa0 = a1_i0_r; wa1 = a1_i1_r;
        wd0_re = rd1_re_r; wd0_im = rd1_im_r;
        wd1_re = rd0_re_r; wd1_im = rd0_im_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we0) begin mem_re[wa0] <= wd0_re; mem_im[wa0] <= wd0_im; end
    if (we1) begin mem_re[wa1] <= wd1_re; mem_im[wa1] <= wd1_im; end
  end

  logic issue;
  assign issue = (state_r == S_GATE || state_r == S_SWAP) && !cnt_r[AW];

  always_ff @(posedge clk) begin
    a1_i0_r <= i0; a1_i1_r <= i1;
    a2_i0_r <= a1_i0_r; a2_i1_r <= a1_i1_r;
    if (!rst_n) begin
      state_r <= S_CLEAR; cnt_r <= '0;
      job_r <= '0;
      v1_r <= 1'b0; v2_r <= 1'b0;
      out_strobe_r <= 1'b0; out_isrd_r <= 1'b0;
      out_re_r <= '0; out_im_r <= '0;
    end else begin
      if (q_pop) job_r <= q_job;
      v1_r <= issue; v2_r <= v1_r && state_r == S_GATE;
      out_strobe_r <= 1'b0; out_isrd_r <= 1'b0;
      out_re_r <= '0; out_im_r <= '0;
      case (state_r)
        S_CLEAR: begin
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r[AW-1:0] == '1) begin state_r <= S_IDLE; cnt_r <= '0; end
        end
        S_IDLE: begin
          cnt_r <= '0;
          if (q_pop) begin
            case (q_job.op)
              svge_pkg::OP_READ:  state_r <= S_READ;
              svge_pkg::OP_RESET: state_r <= S_CLEAR;
              svge_pkg::OP_GATE:  state_r <= S_GATE;
              svge_pkg::OP_SWAP:  state_r <= S_SWAP;
              default:            out_strobe_r <= 1'b1;
            endcase
          end
        end
        S_READ: begin
          out_strobe_r <= 1'b1; out_isrd_r <= 1'b1;
          out_re_r <= rd0_re_r; out_im_r <= rd0_im_r;
          state_r <= S_IDLE;
        end
        S_GATE, S_SWAP: begin
          if (!cnt_r[AW]) cnt_r <= last_issue ? {1'b1, AW'(0)} : cnt_r + 1'b1;
          // drain: finish when nothing is left in the pipe
          if (cnt_r[AW] && !v1_r && !v2_r) begin
            out_strobe_r <= 1'b1; state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
      if (state_r == S_CLEAR && cnt_r[AW-1:0] == '1 && job_r.op == svge_pkg::OP_RESET)
        out_strobe_r <= 1'b1;
    end
  end

  assign out_strobe       = out_strobe_r;
  assign out_real         = out_re_r;
  assign out_imag         = out_im_r;
  assign out_is_read_data = out_isrd_r;
endmodule

/* hdl/state_vector_gate_engine_core.sv */
// State vector gate engine, top level. Depends on svge_pkg, svge_front, svge_queue, svge_back.
// Gate and swap commands sweep the amplitude pairs at one amplitude pair per cycle.
// Throughput: one command at a time in the back end; up to two more wait in the queue.
// Reset (rst_n synchronous low): a clearing sweep loads the basis state; commands queue
// meanwhile. One result strobe per command; the receiver cannot stall.
`timescale 1ns / 1ps
module state_vector_gate_engine_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [2:0]                     in_cmd,
  input  logic [svge_pkg::AW-1:0]        in_amp_index,
  input  logic signed [svge_pkg::DW-1:0] in_real,
  input  logic signed [svge_pkg::DW-1:0] in_imag,
  input  logic [svge_pkg::QW-1:0]        in_target_qubit,
  input  logic [svge_pkg::QW-1:0]        in_control_qubit_a,
  input  logic [svge_pkg::QW-1:0]        in_control_qubit_b,
  input  logic                           cfg_we,
  input  logic [2:0]                     cfg_index,
  input  logic [svge_pkg::DW-1:0]        cfg_data,
  output logic                           out_strobe,
  output logic signed [svge_pkg::DW-1:0] out_real,
  output logic signed [svge_pkg::DW-1:0] out_imag,
  output logic                           out_is_read_data
);
  logic signed [svge_pkg::DW-1:0] coef_r [8];
  logic           q_full, q_push, q_pop, q_ne;
  svge_pkg::job_t q_in, q_head;

  // Hold matrix coefficients; reset to identity.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < 8; k++) coef_r[k] <= '0;
      coef_r[svge_pkg::CFG_R00] <= svge_pkg::DW'(svge_pkg::ONE);
      coef_r[svge_pkg::CFG_R11] <= svge_pkg::DW'(svge_pkg::ONE);
    end else if (cfg_we) begin
      coef_r[cfg_index] <= cfg_data;
    end
  end

  svge_front u_front (
    .in_start(start), .in_busy(busy), .in_cmd, .in_amp_index,
    .in_real, .in_imag, .in_target_qubit, .in_control_qubit_a, .in_control_qubit_b,
    .q_full, .q_push, .q_job(q_in)
  );

  svge_queue u_queue (
    .clk, .rst_n, .push(q_push), .push_job(q_in), .full(q_full),
    .pop(q_pop), .not_empty(q_ne), .head(q_head)
  );

  svge_back u_back (
    .clk, .rst_n, .q_valid(q_ne), .q_job(q_head), .q_pop, .coef(coef_r),
    .out_strobe, .out_real, .out_imag, .out_is_read_data
  );
endmodule
